>>> hw/rtl/oct_pkg.sv
package oct_pkg;

   localparam int ARC_W         = 13;
   localparam int EDGE_W        = 10;
   localparam int CNT_W         = 11;
   localparam int DEG_W         = 14;
   localparam int STEP_W        = 13;
   localparam int MAX_SLOTS     = 1024;
   localparam int DEFAULT_EDGES = 1024;
   localparam logic [DEG_W-1:0] DEG_CAP = 14'd8192;

   typedef enum logic [2:0] {
      FN_MAKE    = 3'd0,
      FN_DESTROY = 3'd1,
      FN_SPLICE  = 3'd2,
      FN_ROTFLIP = 3'd3,
      FN_WALK    = 3'd4,
      FN_DEGREE  = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_BADSPL  = 2'd2,
      ST_CAP     = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_MK_LOAD, S_MK_WR,
      S_DS_R0, S_DS_C0, S_DS_P0, S_DS_R2, S_DS_C2, S_DS_P2, S_DS_PUSH,
      S_SP_RA, S_SP_TA, S_SP_TB, S_SP_TC, S_SP_TD, S_SP_WR,
      S_WK_ISS, S_WK_USE, S_DG_ISS, S_DG_USE, S_FIN
   } state_type;

   typedef enum logic [1:0] {
      RET_SPLICE, RET_DS0, RET_DS2
   } ret_type;

   // one access to the link store: read or write of one link slot
   typedef struct packed {
      logic              rd;
      logic              wr;
      logic [EDGE_W-1:0] edge_idx;
      logic [1:0]        slot;
      logic [ARC_W-1:0]  wdata;
   } link_cmd_type;

   function automatic logic [ARC_W-1:0] sfix(input logic [ARC_W-1:0] a);
      return {10'd0, a[1] ^ a[0], 2'b00};
   endfunction

   function automatic logic [ARC_W-1:0] t_rot(input logic [ARC_W-1:0] a);
      return a ^ sfix(a) ^ 13'd2;
   endfunction

   function automatic logic [ARC_W-1:0] t_sym(input logic [ARC_W-1:0] a);
      return a ^ 13'd4;
   endfunction

   function automatic logic [ARC_W-1:0] t_tor(input logic [ARC_W-1:0] a);
      return a ^ sfix(a) ^ 13'd6;
   endfunction

   function automatic logic [ARC_W-1:0] t_flip(input logic [ARC_W-1:0] a);
      return a ^ 13'd1;
   endfunction

   function automatic logic [ARC_W-1:0] t_dual(input logic [ARC_W-1:0] a);
      return a ^ sfix(a) ^ 13'd3;
   endfunction

   function automatic logic [ARC_W-1:0] t_duar(input logic [ARC_W-1:0] a);
      return a ^ sfix(a) ^ 13'd7;
   endfunction

   // rot^r with r taken mod 4
   function automatic logic [ARC_W-1:0] rot_pow(input logic [ARC_W-1:0] a,
                                                input logic [1:0] r);
      logic [ARC_W-1:0] e;
      case (r)
         2'd1:    e = t_rot(a);
         2'd2:    e = t_sym(a);
         2'd3:    e = t_tor(a);
         default: e = a;
      endcase
      return e;
   endfunction

   function automatic logic [1:0] onext_slot(input logic [ARC_W-1:0] a);
      logic [ARC_W-1:0] d;
      d = t_duar(a);
      return a[0] ? d[2:1] : a[2:1];
   endfunction

   function automatic logic [1:0] oprev_slot(input logic [ARC_W-1:0] a);
      logic [ARC_W-1:0] r;
      r = t_rot(a);
      return a[0] ? a[2:1] : r[2:1];
   endfunction

   // turn a raw link into onext or oprev of the arc that was looked up
   function automatic logic [ARC_W-1:0] link_fix(input logic [ARC_W-1:0] a,
                                                 input logic prev,
                                                 input logic [ARC_W-1:0] l);
      logic [ARC_W-1:0] v;
      if (prev) v = a[0] ? t_flip(l) : t_rot(l);
      else      v = a[0] ? t_dual(l) : l;
      return v;
   endfunction

   function automatic link_cmd_type rd_cmd(input logic [ARC_W-1:0] a, input logic prev);
      link_cmd_type c;
      c.rd       = 1'b1;
      c.wr       = 1'b0;
      c.edge_idx = a[12:3];
      c.slot     = prev ? oprev_slot(a) : onext_slot(a);
      c.wdata    = '0;
      return c;
   endfunction

   // set onext(a) = v
   function automatic link_cmd_type wr_cmd(input logic [ARC_W-1:0] a,
                                           input logic [ARC_W-1:0] v);
      link_cmd_type c;
      c.rd       = 1'b0;
      c.wr       = 1'b1;
      c.edge_idx = a[12:3];
      c.slot     = onext_slot(a);
      c.wdata    = a[0] ? t_dual(v) : v;
      return c;
   endfunction

   function automatic link_cmd_type raw_cmd(input logic rd, input logic wr,
                                            input logic [EDGE_W-1:0] ed,
                                            input logic [1:0] slot,
                                            input logic [ARC_W-1:0] v);
      link_cmd_type c;
      c.rd       = rd;
      c.wr       = wr;
      c.edge_idx = ed;
      c.slot     = slot;
      c.wdata    = v;
      return c;
   endfunction

endpackage

>>> hw/rtl/oct_req_if.sv
interface oct_req_if;
   logic                               valid;
   logic                               ready;
   logic [2:0]                         func;
   logic [oct_pkg::ARC_W-1:0]          arc_a;
   logic [oct_pkg::ARC_W-1:0]          arc_b;
   logic [1:0]                         rot_count;
   logic                               flip_flag;
   logic signed [oct_pkg::STEP_W-1:0]  step_count;

   modport source (output valid, func, arc_a, arc_b, rot_count, flip_flag, step_count,
                   input ready);
   modport sink   (input valid, func, arc_a, arc_b, rot_count, flip_flag, step_count,
                   output ready);
endinterface

>>> hw/rtl/oct_rsp_if.sv
interface oct_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [oct_pkg::ARC_W-1:0] result_arc;
   logic [oct_pkg::DEG_W-1:0] ring_degree;
   logic [1:0]                status;

   modport source (output valid, result_arc, ring_degree, status, input ready);
   modport sink   (input valid, result_arc, ring_degree, status, output ready);
endinterface

>>> hw/rtl/oct_edge_topology_engine.sv
// Channel  Dir  Payload                                                   Moves when
// req      in   func, arc_a, arc_b, rot_count, flip_flag, step_count      valid && ready
// rsp      out  result_arc, ring_degree, status                           valid && ready
//
// One transaction is worked at a time through the link store, whose single port
// sets the pace: each link read is split into an issue step and a use step, each
// write is a single port access.
// Reset clears the bump pointer, the free-stack count and all handshake state;
// link and free-stack memories are not cleared.
// A new transaction is taken while the previous result still waits on rsp.
module oct_edge_topology_engine #(
   parameter int EDGES = oct_pkg::DEFAULT_EDGES
) (
   input  logic     clock,
   input  logic     reset,
   oct_req_if.sink  req,
   oct_rsp_if.source rsp
);
   localparam int SLOTS = (EDGES < oct_pkg::MAX_SLOTS) ? EDGES : oct_pkg::MAX_SLOTS;
   localparam int SW    = $clog2(SLOTS);
   localparam logic [oct_pkg::CNT_W-1:0] SLOTS_C = oct_pkg::CNT_W'(SLOTS);

   oct_pkg::state_type  state_ff, state_in;
   oct_pkg::ret_type    ret_ff, ret_in;
   oct_pkg::link_cmd_type cmd;
   logic [oct_pkg::ARC_W-1:0] rdata, val;

   logic [oct_pkg::ARC_W-1:0] a_ff, a_in;
   logic [oct_pkg::ARC_W-1:0] sa_ff, sa_in, sb_ff, sb_in;
   logic [oct_pkg::ARC_W-1:0] ta_ff, ta_in, tb_ff, tb_in, tc_ff, tc_in, td_ff, td_in;
   logic [oct_pkg::ARC_W-1:0] cur_ff, cur_in, rq_arc_ff, rq_arc_in;
   logic                      rq_prev_ff, rq_prev_in;
   logic [1:0]                r_ff, r_in, wcnt_ff, wcnt_in;
   logic signed [oct_pkg::STEP_W-1:0] n_ff, n_in;
   logic [oct_pkg::EDGE_W-1:0] ed_ff, ed_in;
   logic [oct_pkg::ARC_W-1:0] res_ff, res_in;
   logic [oct_pkg::DEG_W-1:0] deg_ff, deg_in, deg_inc;
   logic [1:0]                st_ff, st_in;
   logic [oct_pkg::CNT_W-1:0] nu_ff, nu_in, fc_ff, fc_in, fc_dec;

   logic                      out_v_ff, out_v_in;
   logic [oct_pkg::ARC_W-1:0] out_arc_ff;
   logic [oct_pkg::DEG_W-1:0] out_deg_ff;
   logic [1:0]                out_st_ff;
   logic                      load_out;

   logic [oct_pkg::EDGE_W-1:0] stk [SLOTS];
   logic [oct_pkg::EDGE_W-1:0] stk_q_ff;
   logic                      push_en, pop_en;

   logic                      accept;
   logic [oct_pkg::ARC_W-1:0] mk_e;

   oct_link_store #(.EDGES(EDGES)) u_store (
      .clock (clock),
      .cmd   (cmd),
      .rdata (rdata)
   );

   assign req.ready = (state_ff == oct_pkg::S_IDLE);
   assign accept    = req.valid && req.ready;
   assign val       = oct_pkg::link_fix(rq_arc_ff, rq_prev_ff, rdata);
   assign fc_dec    = fc_ff - 1'b1;
   assign deg_inc   = deg_ff + 1'b1;
   assign mk_e      = {ed_ff, 3'b000};

   // free stack: push on destroy, registered pop on make
   always_ff @(posedge clock) begin
      if (push_en) begin
         stk[fc_ff[SW-1:0]] <= ed_ff;
      end
      if (pop_en) begin
         stk_q_ff <= stk[fc_dec[SW-1:0]];
      end
   end

   // sequencer: next state, link commands and working registers
   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      a_in       = a_ff;
      sa_in      = sa_ff;
      sb_in      = sb_ff;
      ta_in      = ta_ff;
      tb_in      = tb_ff;
      tc_in      = tc_ff;
      td_in      = td_ff;
      cur_in     = cur_ff;
      rq_arc_in  = rq_arc_ff;
      rq_prev_in = rq_prev_ff;
      r_in       = r_ff;
      wcnt_in    = wcnt_ff;
      n_in       = n_ff;
      ed_in      = ed_ff;
      res_in     = res_ff;
      deg_in     = deg_ff;
      st_in      = st_ff;
      nu_in      = nu_ff;
      fc_in      = fc_ff;
      push_en    = 1'b0;
      pop_en     = 1'b0;
      load_out   = 1'b0;
      cmd        = oct_pkg::raw_cmd(1'b0, 1'b0, '0, 2'd0, '0);

      unique case (state_ff)
         oct_pkg::S_IDLE: begin
            if (accept) begin
               a_in   = req.arc_a;
               r_in   = req.rot_count;
               n_in   = req.step_count;
               ed_in  = req.arc_a[12:3];
               res_in = '0;
               deg_in = '0;
               st_in  = oct_pkg::ST_OK;
               state_in = oct_pkg::S_FIN;
               case (req.func)
                  oct_pkg::FN_MAKE: begin
                     if (fc_ff != '0) begin
                        pop_en   = 1'b1;
                        fc_in    = fc_dec;
                        state_in = oct_pkg::S_MK_LOAD;
                     end else if (nu_ff < SLOTS_C) begin
                        ed_in    = nu_ff[oct_pkg::EDGE_W-1:0];
                        nu_in    = nu_ff + 1'b1;
                        wcnt_in  = 2'd0;
                        state_in = oct_pkg::S_MK_WR;
                     end else begin
                        st_in = oct_pkg::ST_FULL;
                     end
                  end
                  oct_pkg::FN_DESTROY: state_in = oct_pkg::S_DS_R0;
                  oct_pkg::FN_SPLICE: begin
                     sa_in    = req.arc_a;
                     sb_in    = req.arc_b;
                     ret_in   = oct_pkg::RET_SPLICE;
                     state_in = oct_pkg::S_SP_RA;
                  end
                  oct_pkg::FN_ROTFLIP: begin
                     res_in = oct_pkg::rot_pow(req.arc_a, req.rot_count)
                              ^ {12'd0, req.flip_flag};
                  end
                  oct_pkg::FN_WALK: begin
                     cur_in   = oct_pkg::rot_pow(req.arc_a, req.rot_count);
                     state_in = oct_pkg::S_WK_ISS;
                  end
                  oct_pkg::FN_DEGREE: begin
                     cur_in   = req.arc_a;
                     state_in = oct_pkg::S_DG_ISS;
                  end
                  default: ;
               endcase
            end
         end

         oct_pkg::S_MK_LOAD: begin
            ed_in    = stk_q_ff;
            wcnt_in  = 2'd0;
            state_in = oct_pkg::S_MK_WR;
         end

         // write the isolated-edge links b, b.tor, b.sym, b.rot
         oct_pkg::S_MK_WR: begin
            res_in = mk_e;
            case (wcnt_ff)
               2'd0:    cmd = oct_pkg::raw_cmd(1'b0, 1'b1, ed_ff, wcnt_ff, mk_e);
               2'd1:    cmd = oct_pkg::raw_cmd(1'b0, 1'b1, ed_ff, wcnt_ff,
                                               oct_pkg::t_tor(mk_e));
               2'd2:    cmd = oct_pkg::raw_cmd(1'b0, 1'b1, ed_ff, wcnt_ff,
                                               oct_pkg::t_sym(mk_e));
               default: cmd = oct_pkg::raw_cmd(1'b0, 1'b1, ed_ff, wcnt_ff,
                                               oct_pkg::t_rot(mk_e));
            endcase
            wcnt_in = wcnt_ff + 1'b1;
            if (wcnt_ff == 2'd3) state_in = oct_pkg::S_FIN;
         end

         oct_pkg::S_DS_R0: begin
            cmd      = oct_pkg::raw_cmd(1'b1, 1'b0, ed_ff, 2'd0, '0);
            state_in = oct_pkg::S_DS_C0;
         end

         oct_pkg::S_DS_C0: begin
            if (rdata[12:3] != ed_ff) begin
               cmd        = oct_pkg::rd_cmd(a_ff, 1'b1);
               rq_arc_in  = a_ff;
               rq_prev_in = 1'b1;
               state_in   = oct_pkg::S_DS_P0;
            end else begin
               state_in = oct_pkg::S_DS_R2;
            end
         end

         oct_pkg::S_DS_P0: begin
            sa_in    = a_ff;
            sb_in    = val;
            ret_in   = oct_pkg::RET_DS0;
            state_in = oct_pkg::S_SP_RA;
         end

         oct_pkg::S_DS_R2: begin
            cmd      = oct_pkg::raw_cmd(1'b1, 1'b0, ed_ff, 2'd2, '0);
            state_in = oct_pkg::S_DS_C2;
         end

         oct_pkg::S_DS_C2: begin
            if (rdata[12:3] != ed_ff) begin
               cmd        = oct_pkg::rd_cmd(oct_pkg::t_sym(a_ff), 1'b1);
               rq_arc_in  = oct_pkg::t_sym(a_ff);
               rq_prev_in = 1'b1;
               state_in   = oct_pkg::S_DS_P2;
            end else begin
               state_in = oct_pkg::S_DS_PUSH;
            end
         end

         oct_pkg::S_DS_P2: begin
            sa_in    = oct_pkg::t_sym(a_ff);
            sb_in    = val;
            ret_in   = oct_pkg::RET_DS2;
            state_in = oct_pkg::S_SP_RA;
         end

         // drop the push when the free stack is full
         oct_pkg::S_DS_PUSH: begin
            if (fc_ff < SLOTS_C) begin
               push_en = 1'b1;
               fc_in   = fc_ff + 1'b1;
            end
            state_in = oct_pkg::S_FIN;
         end

         oct_pkg::S_SP_RA: begin
            cmd        = oct_pkg::rd_cmd(sa_ff, 1'b0);
            rq_arc_in  = sa_ff;
            rq_prev_in = 1'b0;
            state_in   = oct_pkg::S_SP_TA;
         end

         // ta = onext(a); reject b == fflip(ta), skip a == b
         oct_pkg::S_SP_TA: begin
            ta_in = val;
            if (sb_ff == oct_pkg::t_flip(val)) begin
               st_in    = oct_pkg::ST_BADSPL;
               state_in = oct_pkg::S_FIN;
            end else if (sa_ff == sb_ff) begin
               case (ret_ff)
                  oct_pkg::RET_DS0: state_in = oct_pkg::S_DS_R2;
                  oct_pkg::RET_DS2: state_in = oct_pkg::S_DS_PUSH;
                  default:          state_in = oct_pkg::S_FIN;
               endcase
            end else begin
               cmd        = oct_pkg::rd_cmd(sb_ff, 1'b0);
               rq_arc_in  = sb_ff;
               rq_prev_in = 1'b0;
               state_in   = oct_pkg::S_SP_TB;
            end
         end

         oct_pkg::S_SP_TB: begin
            tb_in      = val;
            cmd        = oct_pkg::rd_cmd(oct_pkg::t_rot(ta_ff), 1'b0);
            rq_arc_in  = oct_pkg::t_rot(ta_ff);
            rq_prev_in = 1'b0;
            state_in   = oct_pkg::S_SP_TC;
         end

         oct_pkg::S_SP_TC: begin
            tc_in      = val;
            cmd        = oct_pkg::rd_cmd(oct_pkg::t_rot(tb_ff), 1'b0);
            rq_arc_in  = oct_pkg::t_rot(tb_ff);
            rq_prev_in = 1'b0;
            state_in   = oct_pkg::S_SP_TD;
         end

         oct_pkg::S_SP_TD: begin
            td_in    = val;
            wcnt_in  = 2'd0;
            state_in = oct_pkg::S_SP_WR;
         end

         // all four reads are done before the first write
         oct_pkg::S_SP_WR: begin
            case (wcnt_ff)
               2'd0:    cmd = oct_pkg::wr_cmd(sa_ff, tb_ff);
               2'd1:    cmd = oct_pkg::wr_cmd(sb_ff, ta_ff);
               2'd2:    cmd = oct_pkg::wr_cmd(oct_pkg::t_rot(ta_ff), td_ff);
               default: cmd = oct_pkg::wr_cmd(oct_pkg::t_rot(tb_ff), tc_ff);
            endcase
            wcnt_in = wcnt_ff + 1'b1;
            if (wcnt_ff == 2'd3) begin
               case (ret_ff)
                  oct_pkg::RET_DS0: state_in = oct_pkg::S_DS_R2;
                  oct_pkg::RET_DS2: state_in = oct_pkg::S_DS_PUSH;
                  default:          state_in = oct_pkg::S_FIN;
               endcase
            end
         end

         oct_pkg::S_WK_ISS: begin
            if (n_ff == '0) begin
               res_in   = oct_pkg::rot_pow(cur_ff, 2'd0 - r_ff);
               state_in = oct_pkg::S_FIN;
            end else begin
               cmd        = oct_pkg::rd_cmd(cur_ff, n_ff[oct_pkg::STEP_W-1]);
               rq_arc_in  = cur_ff;
               rq_prev_in = n_ff[oct_pkg::STEP_W-1];
               state_in   = oct_pkg::S_WK_USE;
            end
         end

         // move the step count one closer to zero
         oct_pkg::S_WK_USE: begin
            cur_in   = val;
            n_in     = n_ff[oct_pkg::STEP_W-1] ? n_ff + 13'sd1 : n_ff - 13'sd1;
            state_in = oct_pkg::S_WK_ISS;
         end

         oct_pkg::S_DG_ISS: begin
            cmd        = oct_pkg::rd_cmd(cur_ff, 1'b0);
            rq_arc_in  = cur_ff;
            rq_prev_in = 1'b0;
            state_in   = oct_pkg::S_DG_USE;
         end

         // count one arc; stop when the ring closes or at the cap
         oct_pkg::S_DG_USE: begin
            cur_in = val;
            deg_in = deg_inc;
            if (val == a_ff) begin
               state_in = oct_pkg::S_FIN;
            end else if (deg_inc == oct_pkg::DEG_CAP) begin
               st_in    = oct_pkg::ST_CAP;
               state_in = oct_pkg::S_FIN;
            end else begin
               state_in = oct_pkg::S_DG_ISS;
            end
         end

         // hand the result over once the output register is free
         oct_pkg::S_FIN: begin
            if (!out_v_ff || rsp.ready) begin
               load_out = 1'b1;
               state_in = oct_pkg::S_IDLE;
            end
         end

         default: state_in = oct_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      out_v_in = out_v_ff;
      if (rsp.ready) out_v_in = 1'b0;
      if (load_out)  out_v_in = 1'b1;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oct_pkg::S_IDLE;
         nu_ff    <= '0;
         fc_ff    <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         nu_ff    <= nu_in;
         fc_ff    <= fc_in;
         out_v_ff <= out_v_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      ret_ff     <= ret_in;
      a_ff       <= a_in;
      sa_ff      <= sa_in;
      sb_ff      <= sb_in;
      ta_ff      <= ta_in;
      tb_ff      <= tb_in;
      tc_ff      <= tc_in;
      td_ff      <= td_in;
      cur_ff     <= cur_in;
      rq_arc_ff  <= rq_arc_in;
      rq_prev_ff <= rq_prev_in;
      r_ff       <= r_in;
      wcnt_ff    <= wcnt_in;
      n_ff       <= n_in;
      ed_ff      <= ed_in;
      res_ff     <= res_in;
      deg_ff     <= deg_in;
      st_ff      <= st_in;
      if (load_out) begin
         out_arc_ff <= res_ff;
         out_deg_ff <= deg_ff;
         out_st_ff  <= st_ff;
      end
   end

   assign rsp.valid       = out_v_ff;
   assign rsp.result_arc  = out_arc_ff;
   assign rsp.ring_degree = out_deg_ff;
   assign rsp.status      = out_st_ff;

   a_fc_bound: assert property (@(posedge clock) disable iff (reset)
      fc_ff <= SLOTS_C) else $error("free count beyond store size");

   a_nu_bound: assert property (@(posedge clock) disable iff (reset)
      nu_ff <= SLOTS_C) else $error("bump pointer beyond store size");

   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd && cmd.wr)) else $error("link store read and write in one cycle");

   a_stk_excl: assert property (@(posedge clock) disable iff (reset)
      !(push_en && pop_en)) else $error("free stack push and pop together");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req.ready) else $error("transaction taken while busy");
endmodule

>>> hw/rtl/oct_link_store.sv
module oct_link_store #(
   parameter int EDGES = oct_pkg::DEFAULT_EDGES
) (
   input  logic                      clock,
   input  oct_pkg::link_cmd_type     cmd,
   output logic [oct_pkg::ARC_W-1:0] rdata
);
   localparam int SLOTS = (EDGES < oct_pkg::MAX_SLOTS) ? EDGES : oct_pkg::MAX_SLOTS;
   localparam int DEPTH = SLOTS * 4;
   localparam int AW    = $clog2(DEPTH);

   logic [oct_pkg::ARC_W-1:0] mem [DEPTH];
   logic [oct_pkg::ARC_W-1:0] q_ff;
   logic                      oob_ff;
   logic [oct_pkg::EDGE_W+1:0] full_addr;
   logic [AW-1:0]             addr;
   logic                      in_range;

   // records beyond the store read as arc 0 and drop writes
   assign full_addr = {cmd.edge_idx, cmd.slot};
   assign addr      = full_addr[AW-1:0];
   assign in_range  = ({1'b0, cmd.edge_idx} < (oct_pkg::EDGE_W+1)'(SLOTS));

   // write and registered read, one port
   always_ff @(posedge clock) begin
      if (cmd.wr && in_range) begin
         mem[addr] <= cmd.wdata;
      end
      if (cmd.rd) begin
         oob_ff <= !in_range;
         if (in_range) begin
            q_ff <= mem[addr];
         end
      end
   end

   assign rdata = oob_ff ? '0 : q_ff;
endmodule
